FILE: rtl/i2c_register_transaction_sequencer_assert.svh
// Assertion macros shared by the sequencer RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef I2C_REGISTER_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_REGISTER_TRANSACTION_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define I2CRTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define I2CRTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/i2crts_pkg.sv
package i2crts_pkg;

    localparam int unsigned LIMIT_W = 18;

    localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 18'd200000;

    typedef enum logic [1:0] {
        KIND_POLL  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_WRITE   = 3'd2,
        ACT_CLRADDR = 3'd3,
        ACT_STOP    = 3'd4
    } action_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_SB1   = 4'd1,
        PH_ADDR1 = 4'd2,
        PH_TXE   = 4'd3,
        PH_PTR   = 4'd4,
        PH_DATA  = 4'd5,
        PH_SB2   = 4'd6,
        PH_ADDR2 = 4'd7,
        PH_RX    = 4'd8
    } phase_t;

    // Completion status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TO_START  = 3'd1;
    localparam logic [2:0] ST_TO_ADDR   = 3'd2;
    localparam logic [2:0] ST_TO_TXE    = 3'd3;
    localparam logic [2:0] ST_TO_PTR    = 3'd4;
    localparam logic [2:0] ST_TO_SB2    = 3'd5;
    localparam logic [2:0] ST_TO_RADDR  = 3'd6;
    localparam logic [2:0] ST_TO_RX     = 3'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] slave_address;
        logic [7:0] register_index;
        logic [7:0] write_value;
        logic       start_sent;
        logic       address_acked;
        logic       tx_empty;
        logic       byte_done;
        logic       rx_ready;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_data;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] read_data;
        logic       busy_res;
    } res_t;

    typedef struct packed {
        phase_t             phase;
        logic               is_read;
        logic [6:0]         held_address;
        logic [7:0]         held_register;
        logic [7:0]         held_value;
        logic [LIMIT_W-1:0] wait_budget;
    } seq_state_t;

endpackage

FILE: rtl/i2crts_step.sv
module i2crts_step
    import i2crts_pkg::*;
(
    input  seq_state_t         cur,
    input  req_t               item,
    input  logic [LIMIT_W-1:0] timeout_limit,
    output seq_state_t         nxt,
    output res_t               res
);

    logic               flag;
    logic [2:0]         code;
    logic [LIMIT_W-1:0] load_value;
    logic [LIMIT_W-1:0] budget_dec;
    logic               is_idle;

    // A zero limit counts as one
    assign load_value = (timeout_limit == '0) ? LIMIT_W'(1) : timeout_limit;
    assign budget_dec = cur.wait_budget - LIMIT_W'(1);

    always_comb
    begin
        flag    = 1'b0;
        code    = ST_OK;
        is_idle = 1'b0;
        unique case (cur.phase)
            PH_SB1:   begin flag = item.start_sent;    code = ST_TO_START; end
            PH_ADDR1: begin flag = item.address_acked; code = ST_TO_ADDR;  end
            PH_TXE:   begin flag = item.tx_empty;      code = ST_TO_TXE;   end
            PH_PTR:   begin flag = item.byte_done;     code = ST_TO_PTR;   end
            PH_DATA:  begin flag = item.byte_done;     code = ST_TO_SB2;   end
            PH_SB2:   begin flag = item.start_sent;    code = ST_TO_SB2;   end
            PH_ADDR2: begin flag = item.address_acked; code = ST_TO_RADDR; end
            PH_RX:    begin flag = item.rx_ready;      code = ST_TO_RX;    end
            default:  is_idle = 1'b1;
        endcase
    end

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (is_idle)
        begin
            nxt.phase = PH_IDLE;
            if (item.kind == KIND_READ || item.kind == KIND_WRITE)
            begin
                nxt.is_read       = (item.kind == KIND_READ);
                nxt.held_address  = item.slave_address;
                nxt.held_register = item.register_index;
                nxt.held_value    = item.write_value;
                nxt.wait_budget   = load_value;
                nxt.phase         = PH_SB1;
                res.action        = ACT_START;
            end
        end
        else if (!flag)
        begin
            // Count down; expiry ends the transaction without STOP
            nxt.wait_budget = budget_dec;
            if (budget_dec == '0)
            begin
                res.done_res = 1'b1;
                res.status   = code;
                nxt.phase    = PH_IDLE;
            end
        end
        else
        begin
            nxt.wait_budget = load_value;
            case (cur.phase)
                PH_SB1:
                begin
                    res.action  = ACT_WRITE;
                    res.tx_data = {cur.held_address, 1'b0};
                    nxt.phase   = PH_ADDR1;
                end
                PH_ADDR1:
                begin
                    res.action = ACT_CLRADDR;
                    nxt.phase  = PH_TXE;
                end
                PH_TXE:
                begin
                    res.action  = ACT_WRITE;
                    res.tx_data = cur.held_register;
                    nxt.phase   = PH_PTR;
                end
                PH_PTR:
                begin
                    if (cur.is_read)
                    begin
                        res.action = ACT_START;
                        nxt.phase  = PH_SB2;
                    end
                    else
                    begin
                        res.action  = ACT_WRITE;
                        res.tx_data = cur.held_value;
                        nxt.phase   = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    res.action   = ACT_STOP;
                    res.done_res = 1'b1;
                    nxt.phase    = PH_IDLE;
                end
                PH_SB2:
                begin
                    res.action  = ACT_WRITE;
                    res.tx_data = {cur.held_address, 1'b1};
                    nxt.phase   = PH_ADDR2;
                end
                PH_ADDR2:
                begin
                    res.action = ACT_CLRADDR;
                    nxt.phase  = PH_RX;
                end
                default:
                begin
                    res.action    = ACT_STOP;
                    res.read_data = item.rx_byte;
                    res.done_res  = 1'b1;
                    nxt.phase     = PH_IDLE;
                end
            endcase
        end
        res.busy_res = (nxt.phase != PH_IDLE);
    end

endmodule

FILE: rtl/i2c_register_transaction_sequencer.sv
// I2C master register access sequencer. Each request is one polling tick: it may
// carry a read or write command plus the controller's status flags and receive
// byte, and it yields exactly one result telling the controller what to do next
// (start, write byte, clear address status, stop) along with done, status,
// read data and busy. Requests are taken one per cycle with no bubbles unless the
// result stalls; one request can then still wait in the input register. A request
// passes through the input register and then the result register, and the phase
// and wait budget registers update once per request taken. Each wait gives up
// after timeout_limit consecutive ticks with its flag clear (reset value 200000)
// and reports a status code for its phase (the data wait shares the SB2 code)
// with no STOP. Commands that arrive while a transaction is in progress are
// ignored. Write timeout_limit only while no request is in flight.
module i2c_register_transaction_sequencer
    import i2crts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,

    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_timeout_limit
);

    // Input stage: hold one request until the step logic consumes it
    logic               s1_valid_reg;
    req_t               s1_item_reg;

    // Sequencer state, advanced once per consumed request
    seq_state_t         state_reg;
    seq_state_t         state_next;

    // Result register, parted from the input side so a stalled result
    // does not block the next request from being registered
    logic               res_valid_reg;
    res_t               res_reg;
    res_t               res_next;

    logic [LIMIT_W-1:0] timeout_limit_reg;
    logic               advance;

    // Consume the held request when the result slot is free or draining
    assign advance   = s1_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    i2crts_step u_step (
        .cur           (state_reg),
        .item          (s1_item_reg),
        .timeout_limit (timeout_limit_reg),
        .nxt           (state_next),
        .res           (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_limit_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_limit_reg <= cfg_timeout_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    // Payload: load on accept only
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_item_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, is_read: 1'b0, held_address: '0,
                           held_register: '0, held_value: '0, wait_budget: '0};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

`include "i2c_register_transaction_sequencer_assert.svh"

    // A finished transaction always leaves the sequencer idle
    `I2CRTS_ASSERT_NEXT(a_done_goes_idle,
        advance && res_next.done_res,
        state_reg.phase == PH_IDLE,
        "done result did not return to idle")

    // A new command from idle issues START and enters the first wait
    `I2CRTS_ASSERT_NEXT(a_start_enters_sb1,
        advance && state_reg.phase == PH_IDLE && res_next.action == ACT_START,
        state_reg.phase == PH_SB1,
        "start from idle did not enter first wait")

    // A timeout status only comes with done and no controller action
    `I2CRTS_ASSERT_NOW(a_timeout_is_done,
        res_valid_reg && res_reg.status != ST_OK,
        res_reg.done_res && res_reg.action == ACT_NONE,
        "timeout status without done or with an action")

    // A held request waiting on a stalled result stays held
    `I2CRTS_ASSERT_NEXT(a_hold_request,
        s1_valid_reg && !advance,
        s1_valid_reg && $stable(s1_item_reg),
        "held request lost while result stalled")

endmodule
